### rtl/drd_pkg.sv
// drd_pkg: shared types and constants for the detection row decoder.
// No dependencies; imported by the top level, the rounding stage and the checker.
package drd_pkg;

    // fixed widths of the result fields
    localparam int COORD_W = 16;
    localparam int LABEL_W = 7;

    // configuration register widths
    localparam int NCLS_W  = 8;
    localparam int THR_W   = 15;
    localparam int FRAME_W = 14;

    // APB port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [NCLS_W-1:0]  NCLS_RST  = 8'd80;
    localparam logic [THR_W-1:0]   THR_RST   = 15'd8192;
    localparam logic [FRAME_W-1:0] FRAME_RST = 14'd640;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_NUM_CLASSES     = 2'd0,
        REG_SCORE_THRESHOLD = 2'd1,
        REG_FRAME_WIDTH     = 2'd2,
        REG_FRAME_HEIGHT    = 2'd3
    } t_reg_idx;

endpackage

### rtl/drd_round_sat.sv
// drd_round_sat: scaled corner product to pixel coordinate.
// Round half to even, then saturate to COORD_W bits. Uses drd_pkg.
module drd_round_sat #(
    parameter int VALUE_BITS = 16
) (
    input  logic signed [VALUE_BITS+16:0]     i_prod,
    output logic signed [drd_pkg::COORD_W-1:0] o_coord
);
    import drd_pkg::*;

    localparam int PW = VALUE_BITS + 17;   // product width
    localparam int SH = VALUE_BITS - 1;    // fraction bits plus the halving
    localparam int QW = PW - SH;           // integer part width
    localparam int RW = QW + 1;            // room for the round-up carry

    localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic signed [QW-1:0] q;
    logic                 guard;
    logic                 sticky;
    logic                 rnd_up;
    logic signed [RW-1:0] q_rnd;

    assign q      = i_prod[PW-1:SH];
    assign guard  = i_prod[SH-1];
    assign sticky = |i_prod[SH-2:0];
    assign rnd_up = guard & (sticky | q[0]);
    assign q_rnd  = {q[QW-1], q} + RW'(rnd_up);

    always_comb begin
        if (q_rnd > SAT_HI) begin
            o_coord = SAT_HI[COORD_W-1:0];
        end else if (q_rnd < SAT_LO) begin
            o_coord = SAT_LO[COORD_W-1:0];
        end else begin
            o_coord = q_rnd[COORD_W-1:0];
        end
    end

endmodule

### rtl/detection_row_decode_top.sv
// detection_row_decode_top: streamed detector row decode (box + class argmax).
// Depends on drd_pkg and drd_round_sat.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------------
//  in       | request   | i_in_valid / o_in_stall | i_tensor_value, i_row_restart
//  out      | result    | o_out_valid / i_out_stall | o_class_label, o_best_score, corners
//  config   | APB       | psel / penable / pready | paddr, pwdata, prdata
//
// One tensor value is taken every cycle unless o_in_stall is high. The argmax compare and row
// position update sit between the input register and the state registers.
// After its last score is accepted, a detection passes through the input
// register, a corner-sum stage, a product stage (four 18x15
// multipliers at default width), then rounding into the output register.
// Each stage refills whenever it is empty, so the input only stalls once a
// held result has backed up through every stage. Reset is synchronous and
// clears control and register state; the row restarts at position zero.
module detection_row_decode_top #(
    parameter int MAX_CLASSES = 128,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // input requests
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [VALUE_BITS-1:0]          i_tensor_value,
    input  logic                                  i_row_restart,

    // results
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [drd_pkg::LABEL_W-1:0]           o_class_label,
    output logic signed [VALUE_BITS-1:0]          o_best_score,
    output logic signed [drd_pkg::COORD_W-1:0]    o_left_x,
    output logic signed [drd_pkg::COORD_W-1:0]    o_top_y,
    output logic signed [drd_pkg::COORD_W-1:0]    o_right_x,
    output logic signed [drd_pkg::COORD_W-1:0]    o_bottom_y,

    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [drd_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [drd_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [drd_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import drd_pkg::*;

    localparam int POS_W = $clog2(MAX_CLASSES + 4);
    localparam int CW    = ((POS_W > NCLS_W) ? POS_W : NCLS_W) + 1;
    localparam int NW    = VALUE_BITS + 2;          // 2*centre +/- size
    localparam int PW    = VALUE_BITS + 17;         // sum times frame size
    localparam int SCW   = VALUE_BITS + THR_W + 1;  // score vs threshold

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [NCLS_W-1:0]  r_num_classes;
    logic [THR_W-1:0]   r_score_threshold;
    logic [FRAME_W-1:0] r_frame_width;
    logic [FRAME_W-1:0] r_frame_height;
    t_reg_idx           reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes     <= NCLS_RST;
            r_score_threshold <= THR_RST;
            r_frame_width     <= FRAME_RST;
            r_frame_height    <= FRAME_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NUM_CLASSES:     r_num_classes     <= pwdata[NCLS_W-1:0];
                REG_SCORE_THRESHOLD: r_score_threshold <= pwdata[THR_W-1:0];
                REG_FRAME_WIDTH:     r_frame_width     <= pwdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_height    <= pwdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_CLASSES:     prdata = APB_DATA_W'(r_num_classes);
            REG_SCORE_THRESHOLD: prdata = APB_DATA_W'(r_score_threshold);
            REG_FRAME_WIDTH:     prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT:    prdata = APB_DATA_W'(r_frame_height);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage ready chain (each stage refills when empty)
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic a_emit, a_drain, a_fire, in_ready;
    logic b_ready, c_ready, d_ready;

    assign d_ready  = !r_d_valid || !i_out_stall;
    assign c_ready  = !r_c_valid || d_ready;
    assign b_ready  = !r_b_valid || c_ready;
    assign a_drain  = !a_emit || b_ready;
    assign a_fire   = r_a_valid && a_drain;
    assign in_ready = !r_a_valid || a_drain;

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_d_valid;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] r_a_value;
    logic                         r_a_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_a_value   <= i_tensor_value;
            r_a_restart <= i_row_restart;
        end
    end

    // ------------------------------------------------------------------
    // row position, box store and running argmax
    // ------------------------------------------------------------------
    logic [POS_W-1:0]             r_pos;
    logic signed [VALUE_BITS-1:0] r_box [4];
    logic signed [VALUE_BITS-1:0] r_best;
    logic [LABEL_W-1:0]           r_label;

    logic [POS_W-1:0]             pos;
    logic [CW-1:0]                pos_ext, nc_ext, nc_lim;
    logic                         is_box, is_last, take;
    logic [POS_W-1:0]             idx;
    logic [POS_W+LABEL_W-1:0]     idx_w;
    logic signed [VALUE_BITS-1:0] n_best;
    logic [LABEL_W-1:0]           n_label;
    logic signed [SCW-1:0]        best_ext, thr_ext;

    assign pos     = r_a_restart ? '0 : r_pos;
    assign pos_ext = CW'(pos);
    assign nc_ext  = CW'(r_num_classes);

    // zero count acts as one, an oversized count as the maximum
    always_comb begin
        if (nc_ext == '0) begin
            nc_lim = CW'(1);
        end else if (nc_ext > CW'(MAX_CLASSES)) begin
            nc_lim = CW'(MAX_CLASSES);
        end else begin
            nc_lim = nc_ext;
        end
    end

    assign is_box  = pos_ext < CW'(4);
    // anything at or past the last score closes the row
    assign is_last = pos_ext >= (nc_lim + CW'(3));
    assign idx     = pos - POS_W'(4);
    assign idx_w   = {{LABEL_W{1'b0}}, idx};
    assign take    = (idx == '0) || (r_a_value > r_best);   // first maximum wins ties
    assign n_best  = take ? r_a_value : r_best;
    assign n_label = take ? idx_w[LABEL_W-1:0] : r_label;

    assign best_ext = SCW'(n_best);
    assign thr_ext  = $signed({{(SCW-THR_W){1'b0}}, r_score_threshold});
    assign a_emit   = !is_box && is_last && (best_ext >= thr_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (a_fire) begin
            r_pos <= (is_box || !is_last) ? pos + POS_W'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            if (is_box) begin
                r_box[pos[1:0]] <= r_a_value;
            end else begin
                r_best  <= n_best;
                r_label <= n_label;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage B: corner sums 2*centre -/+ size
    // ------------------------------------------------------------------
    logic signed [NW-1:0] cx2, cy2, w_ext, h_ext;
    logic signed [NW-1:0] r_b_x1, r_b_x2, r_b_y1, r_b_y2;
    logic signed [VALUE_BITS-1:0] r_b_score;
    logic [LABEL_W-1:0]           r_b_label;

    assign cx2   = {r_box[0][VALUE_BITS-1], r_box[0], 1'b0};
    assign cy2   = {r_box[1][VALUE_BITS-1], r_box[1], 1'b0};
    assign w_ext = NW'(r_box[2]);
    assign h_ext = NW'(r_box[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= a_fire && a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && a_fire && a_emit) begin
            r_b_x1    <= cx2 - w_ext;
            r_b_x2    <= cx2 + w_ext;
            r_b_y1    <= cy2 - h_ext;
            r_b_y2    <= cy2 + h_ext;
            r_b_score <= n_best;
            r_b_label <= n_label;
        end
    end

    // ------------------------------------------------------------------
    // stage C: scale by frame size
    // ------------------------------------------------------------------
    logic signed [FRAME_W:0]      fw_s, fh_s;
    logic signed [PW-1:0]         r_c_x1, r_c_x2, r_c_y1, r_c_y2;
    logic signed [VALUE_BITS-1:0] r_c_score;
    logic [LABEL_W-1:0]           r_c_label;

    assign fw_s = $signed({1'b0, r_frame_width});
    assign fh_s = $signed({1'b0, r_frame_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_x1    <= PW'(r_b_x1) * PW'(fw_s);
            r_c_x2    <= PW'(r_b_x2) * PW'(fw_s);
            r_c_y1    <= PW'(r_b_y1) * PW'(fh_s);
            r_c_y2    <= PW'(r_b_y2) * PW'(fh_s);
            r_c_score <= r_b_score;
            r_c_label <= r_b_label;
        end
    end

    // ------------------------------------------------------------------
    // stage D: round, saturate, order corners into the output register
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] x1, x2, y1, y2;

    drd_round_sat #(.VALUE_BITS(VALUE_BITS)) u_rs_x1 (.i_prod(r_c_x1), .o_coord(x1));
    drd_round_sat #(.VALUE_BITS(VALUE_BITS)) u_rs_x2 (.i_prod(r_c_x2), .o_coord(x2));
    drd_round_sat #(.VALUE_BITS(VALUE_BITS)) u_rs_y1 (.i_prod(r_c_y1), .o_coord(y1));
    drd_round_sat #(.VALUE_BITS(VALUE_BITS)) u_rs_y2 (.i_prod(r_c_y2), .o_coord(y2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
    end

    // negative sizes swap the corners back into order
    always_ff @(posedge i_clk) begin
        if (d_ready && r_c_valid) begin
            o_class_label <= r_c_label;
            o_best_score  <= r_c_score;
            o_left_x      <= (x1 < x2) ? x1 : x2;
            o_right_x     <= (x1 < x2) ? x2 : x1;
            o_top_y       <= (y1 < y2) ? y1 : y2;
            o_bottom_y    <= (y1 < y2) ? y2 : y1;
        end
    end

endmodule

### rtl/drd_checker.sv
// drd_checker: port-level assertions for detection_row_decode_top.
// Uses drd_pkg; bound to the top level at the end of this file.
module drd_checker #(
    parameter int VALUE_BITS = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [drd_pkg::LABEL_W-1:0]        o_class_label,
    input logic signed [VALUE_BITS-1:0]       o_best_score,
    input logic signed [drd_pkg::COORD_W-1:0] o_left_x,
    input logic signed [drd_pkg::COORD_W-1:0] o_top_y,
    input logic signed [drd_pkg::COORD_W-1:0] o_right_x,
    input logic signed [drd_pkg::COORD_W-1:0] o_bottom_y
);
    import drd_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_class_label)
            && $stable(o_best_score) && $stable(o_left_x) && $stable(o_right_x)
            && $stable(o_top_y) && $stable(o_bottom_y))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // threshold is never negative, so no emitted score is
    a_score_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_best_score[VALUE_BITS-1])
        else $error("negative score emitted");

    // corners come out ordered
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_x <= o_right_x) && (o_top_y <= o_bottom_y))
        else $error("corners out of order");

endmodule

bind detection_row_decode_top drd_checker #(.VALUE_BITS(VALUE_BITS)) u_drd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_class_label (o_class_label),
    .o_best_score  (o_best_score),
    .o_left_x      (o_left_x),
    .o_top_y       (o_top_y),
    .o_right_x     (o_right_x),
    .o_bottom_y    (o_bottom_y)
);

### sim/detection_row_decode_top_test.sv
// Self-checking bench for detection_row_decode_top: streamed box decode and class argmax.
// Depends on drd_pkg and the RTL only. A local predictor forecasts each detection and
// results are checked in order against it.
module detection_row_decode_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import drd_pkg::*;

    localparam int MAX_CLASSES   = 128;
    localparam int SETTLE_CYCLES = 12;   // pipeline drain plus margin
    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int NUM_PHASES    = 14;
    localparam int MAX_REPORTS   = 10;

    // one detection as it leaves the block
    typedef struct packed {
        logic [LABEL_W-1:0]        label;
        logic signed [15:0]        score;
        logic signed [15:0]        left_x;
        logic signed [15:0]        top_y;
        logic signed [15:0]        right_x;
        logic signed [15:0]        bottom_y;
    } t_det;

    // one row of the directed table; pinned rows carry a hand-worked detection
    typedef struct packed {
        logic signed [15:0] tval;
        logic               restart;
        logic               pinned;
        t_det               want;
    } t_stim_row;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [15:0]         i_tensor_value;
    logic                       i_row_restart;

    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [LABEL_W-1:0]         o_class_label;
    logic signed [15:0]         o_best_score;
    logic signed [COORD_W-1:0]  o_left_x;
    logic signed [COORD_W-1:0]  o_top_y;
    logic signed [COORD_W-1:0]  o_right_x;
    logic signed [COORD_W-1:0]  o_bottom_y;

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    detection_row_decode_top #(
        .MAX_CLASSES (MAX_CLASSES),
        .VALUE_BITS  (16)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_tensor_value (i_tensor_value),
        .i_row_restart  (i_row_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_class_label  (o_class_label),
        .o_best_score   (o_best_score),
        .o_left_x       (o_left_x),
        .o_top_y        (o_top_y),
        .o_right_x      (o_right_x),
        .o_bottom_y     (o_bottom_y),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the row tracker.
    // ---------------------------------------------------------------------
    logic [NCLS_W-1:0]  cfg_classes = NCLS_RST;
    logic [THR_W-1:0]   cfg_thresh  = THR_RST;
    logic [FRAME_W-1:0] cfg_fw      = FRAME_RST;
    logic [FRAME_W-1:0] cfg_fh      = FRAME_RST;

    int unsigned        row_pos = 0;
    logic signed [15:0] box_q [4] = '{default: '0};
    logic signed [15:0] lead_score = '0;
    int unsigned        lead_label = 0;

    t_det pending_dets [$];     // detections forecast but not yet seen
    int   mismatches = 0;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    bit   hold_req      = 1'b0;
    bit   hold_taken    = 1'b0;
    int   hold_left     = 0;

    // Directed rows, walked in order with two classes per row, threshold 0,
    // frame width at its top value and frame height zero (all y corners zero).
    localparam t_stim_row DIRECTED_ROWS [0:25] = '{
        // all-zero box, second class wins outright
        '{16'sd0,      1'b1, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd5,      1'b0, 1'b0, '0},
        '{16'sd32767,  1'b0, 1'b1, '{7'd1, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
        // most negative centre and size: left edge saturates, tied scores keep class 0
        '{-16'sd32768, 1'b1, 1'b0, '0},
        '{16'sd32767,  1'b0, 1'b0, '0},
        '{-16'sd32768, 1'b0, 1'b0, '0},
        '{16'sd32767,  1'b0, 1'b0, '0},
        '{16'sd100,    1'b0, 1'b0, '0},
        '{16'sd100,    1'b0, 1'b1,
          '{7'd0, 16'sd100, -16'sd32768, 16'sd0, -16'sd16383, 16'sd0}},
        // restart part way through the box, negative sizes, best score below threshold
        '{16'sd7,      1'b1, 1'b0, '0},
        '{16'sd7,      1'b0, 1'b0, '0},
        '{16'sd9,      1'b1, 1'b0, '0},
        '{16'sd1,      1'b0, 1'b0, '0},
        '{-16'sd1,     1'b0, 1'b0, '0},
        '{-16'sd2,     1'b0, 1'b0, '0},
        '{-16'sd32768, 1'b0, 1'b0, '0},
        '{-16'sd1,     1'b0, 1'b0, '0},
        // row following on without a restart, best score exactly on threshold
        '{16'sd1234,   1'b0, 1'b0, '0},
        '{-16'sd4321,  1'b0, 1'b0, '0},
        '{16'sd16384,  1'b0, 1'b0, '0},
        '{16'sd32767,  1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{-16'sd5,     1'b0, 1'b0, '0}
    };

    // effective class count: zero acts as one, oversize is clipped
    function automatic int unsigned class_count();
        if (cfg_classes == 0)
            return 1;
        if (cfg_classes > MAX_CLASSES)
            return MAX_CLASSES;
        return cfg_classes;
    endfunction

    // One corner: (2*centre +/- size) * scale / 2^15, half to even, saturated.
    function automatic logic signed [15:0] pixel_edge(logic signed [15:0] centre,
                                                      logic signed [15:0] size,
                                                      bit plus, logic [FRAME_W-1:0] scale);
        longint n, q, r;
        n = (2 * longint'(centre) + (plus ? longint'(size) : -longint'(size)))
            * longint'(scale);
        q = n >>> 15;
        r = n - (q <<< 15);
        if (r > 16384 || (r == 16384 && q[0]))
            q = q + 1;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Advance the row tracker by one value; returns 1 when a detection is due.
    function automatic bit track_value(logic signed [15:0] v, bit restart, output t_det d);
        int unsigned pos;
        logic signed [15:0] x1, x2, y1, y2;
        d   = '0;
        pos = restart ? 0 : row_pos;
        if (pos < 4) begin
            box_q[pos] = v;
            row_pos    = pos + 1;
            return 1'b0;
        end
        // running argmax: first score always taken, later ones only if strictly higher
        if (pos == 4 || v > lead_score) begin
            lead_score = v;
            lead_label = pos - 4;
        end
        // a position past the last score (count lowered mid row) still closes the row
        if (pos < 3 + class_count()) begin
            row_pos = pos + 1;
            return 1'b0;
        end
        row_pos = 0;
        if (int'(lead_score) < int'(cfg_thresh))
            return 1'b0;
        x1 = pixel_edge(box_q[0], box_q[2], 1'b0, cfg_fw);
        x2 = pixel_edge(box_q[0], box_q[2], 1'b1, cfg_fw);
        y1 = pixel_edge(box_q[1], box_q[3], 1'b0, cfg_fh);
        y2 = pixel_edge(box_q[1], box_q[3], 1'b1, cfg_fh);
        d.label    = lead_label[LABEL_W-1:0];
        d.score    = lead_score;
        d.left_x   = (x1 < x2) ? x1 : x2;
        d.right_x  = (x1 < x2) ? x2 : x1;
        d.top_y    = (y1 < y2) ? y1 : y2;
        d.bottom_y = (y1 < y2) ? y2 : y1;
        return 1'b1;
    endfunction

    function automatic void report_miss(string what, t_det want, t_det got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, what);
            $display("    exp lbl=%0d sc=%0d box=(%0d,%0d,%0d,%0d)",
                     want.label, want.score, want.left_x, want.top_y,
                     want.right_x, want.bottom_y);
            $display("    got lbl=%0d sc=%0d box=(%0d,%0d,%0d,%0d)",
                     got.label, got.score, got.left_x, got.top_y,
                     got.right_x, got.bottom_y);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result side: stall generator (with long hold-off) and in-order checker.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // sampled at the edge, before this edge's updates land
    always @(posedge i_clk) begin : result_check
        t_det got;
        t_det want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_class_label, o_best_score, o_left_x, o_top_y, o_right_x, o_bottom_y};
            if (pending_dets.size() == 0) begin
                report_miss("result with nothing expected", '0, got);
            end else begin
                want = pending_dets.pop_front();
                if (got !== want)
                    report_miss("result mismatch", want, got);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Request side helpers. All called at a rising edge; inputs change by NBA.
    // ---------------------------------------------------------------------
    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 76; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 76; end
            default:       begin send_idle_pct = 33; stall_pct = 33; end
        endcase
    endtask

    // APB write: setup, access until pready, then back to idle
    task automatic reg_write(t_reg_idx idx, int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_NUM_CLASSES:     cfg_classes = data[NCLS_W-1:0];
            REG_SCORE_THRESHOLD: cfg_thresh  = data[THR_W-1:0];
            REG_FRAME_WIDTH:     cfg_fw      = data[FRAME_W-1:0];
            default:             cfg_fh      = data[FRAME_W-1:0];
        endcase
    endtask

    task automatic set_config(int unsigned ncls, int unsigned thr,
                              int unsigned fw, int unsigned fh);
        reg_write(REG_NUM_CLASSES, ncls);
        reg_write(REG_SCORE_THRESHOLD, thr);
        reg_write(REG_FRAME_WIDTH, fw);
        reg_write(REG_FRAME_HEIGHT, fh);
    endtask

    // Offer one request and hold it until taken; valid never looks at stall.
    task automatic offer_value(logic signed [15:0] v, bit restart,
                               bit pinned = 1'b0, t_det want = '0);
        t_det d;
        bit   due;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_tensor_value <= v;
        i_row_restart  <= restart;
        do @(posedge i_clk); while (o_in_stall);
        due = track_value(v, restart, d);
        if (pinned)
            pending_dets = {pending_dets, want};
        else if (due)
            pending_dets = {pending_dets, d};
    endtask

    // Sender pause: let every forecast detection drain, then let the pipe empty.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_dets.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] box_sample();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(65535));
            1:       return 16'($urandom_range(4096) - 2048);
            2:       return 16'($urandom_range(7) * 8192 - 32768);  // hits exact halves
            default: return 16'($urandom_range(16384));
        endcase
    endfunction

    function automatic logic signed [15:0] score_sample(logic signed [15:0] prev);
        case ($urandom_range(7))
            0:       return {1'b0, cfg_thresh};
            1:       return {1'b0, cfg_thresh} - 16'd1;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return prev;                            // tie with previous score
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Mostly whole rows with random content; some truncated rows and stray values.
    task automatic run_phase(int n_items);
        int sent, kind, row_len, cut;
        bit force_restart;
        logic signed [15:0] s, prev_score;
        sent          = 0;
        force_restart = 1'b0;
        prev_score    = '0;
        while (sent < n_items) begin
            kind    = $urandom_range(99);
            row_len = 4 + class_count();
            if (kind < 6) begin
                offer_value(16'($urandom_range(65535)), 1'($urandom_range(1)));
                sent++;
                force_restart = 1'b1;
            end else begin
                cut = (kind < 14) ? $urandom_range(1, row_len - 1) : row_len;
                for (int k = 0; k < cut && sent < n_items; k++) begin
                    if (k < 4) begin
                        s = box_sample();
                    end else begin
                        s          = score_sample(prev_score);
                        prev_score = s;
                    end
                    offer_value(s, (k == 0) ? (force_restart || $urandom_range(1)) : 1'b0);
                    sent++;
                    if ($urandom_range(299) == 0)
                        wait_for_results();
                end
                force_restart = (cut < row_len);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int budget;
        int unsigned ncls, thr, fw, fh;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_tensor_value <= '0;
        i_row_restart  <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        set_idling(IDLE_NONE);
        set_config(2, 0, 16383, 0);
        foreach (DIRECTED_ROWS[k])
            offer_value(DIRECTED_ROWS[k].tval, DIRECTED_ROWS[k].restart,
                        DIRECTED_ROWS[k].pinned, DIRECTED_ROWS[k].want);
        wait_for_results();

        // random phases; each ends wherever its budget runs out, often mid row,
        // so the next count setting lands on a partly built row
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin ncls = 1;   thr = 0;     fw = 16383; fh = 16383; end
                1: begin ncls = 0;   thr = 32767; fw = 1;     fh = 1;     end  // zero count
                2: begin ncls = 255; thr = 16384; fw = 0;     fh = 8192;  end  // oversize count
                3: begin ncls = 128; thr = 0;     fw = 640;   fh = 480;   end
                default: begin
                    ncls = $urandom_range(1, 12);
                    thr  = $urandom_range(16384);
                    fw   = ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(16383);
                    fh   = ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(16383);
                end
            endcase
            set_idling(t_idle_mode'(p % 4));
            set_config(ncls, thr, fw, fh);
            budget = (class_count() >= MAX_CLASSES) ? 270 : 90;
            run_phase(budget);
            wait_for_results();
        end

        // back-pressure: receiver holds off while requests keep coming
        set_idling(IDLE_NONE);
        set_config(1, 0, 640, 640);
        hold_req = 1'b1;
        run_phase(120);
        wait_for_results();

        if (mismatches == 0 && pending_dets.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
